/* rtl/gas_pkg.sv */
package gas_pkg;

  localparam int unsigned NUM_VERTICES_DEF = 256;
  localparam int unsigned MAX_DEGREE_DEF   = 16;

  localparam int unsigned VERTEX_W = 8;
  localparam int unsigned LABEL_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_READ   = 3'd2,
    KIND_SET    = 3'd3,
    KIND_TEST   = 3'd4,
    KIND_LIST   = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOTFOUND = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

endpackage

/* rtl/gas_row_store.sv */
module gas_row_store
  import gas_pkg::*;
#(
  parameter int unsigned ROWS       = NUM_VERTICES_DEF,
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int unsigned ROW_W      = $clog2(ROWS),
  parameter int unsigned CNT_W      = $clog2(MAX_DEGREE + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [ROW_W-1:0]                     rd_addr_i,
  input  logic                                 wr_en_i,
  input  logic [ROW_W-1:0]                     wr_addr_i,
  input  logic [MAX_DEGREE-1:0][VERTEX_W-1:0]  wr_tgt_i,
  input  logic [MAX_DEGREE-1:0][LABEL_W-1:0]   wr_tag_i,
  input  logic [CNT_W-1:0]                     wr_deg_i,
  output logic [MAX_DEGREE-1:0][VERTEX_W-1:0]  rd_tgt_o,
  output logic [MAX_DEGREE-1:0][LABEL_W-1:0]   rd_tag_o,
  output logic [CNT_W-1:0]                     rd_deg_o
);

  logic [MAX_DEGREE-1:0][VERTEX_W-1:0] tgt_mem [ROWS];
  logic [MAX_DEGREE-1:0][LABEL_W-1:0]  tag_mem [ROWS];
  logic [CNT_W-1:0]                    deg_mem [ROWS];

  logic [ROWS-1:0] row_vld_q;
  logic            rd_vld_q;
  logic [CNT_W-1:0] rd_deg_q;

  // one row word: targets, labels and degree written and read together
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tgt_mem[wr_addr_i] <= wr_tgt_i;
      tag_mem[wr_addr_i] <= wr_tag_i;
      deg_mem[wr_addr_i] <= wr_deg_i;
    end
    if (rd_en_i) begin
      rd_tgt_o <= tgt_mem[rd_addr_i];
      rd_tag_o <= tag_mem[rd_addr_i];
      rd_deg_q <= deg_mem[rd_addr_i];
    end
  end

  // rows never written read back as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_deg_o = rd_vld_q ? rd_deg_q : '0;

endmodule

/* rtl/graph_adjacency_store.sv */
// channel   dir  tdata (low bit up)                               tuser   tlast
// s_axis    in   from_vertex 8, to_vertex 8, label_in 32          kind 3  -
// m_axis    out  status 2, label_out 32, neighbor 8, count 5, pad  -       last
//
// the accept edge launches the row read; the update step then writes the row
// back and loads the result; a listing sends a beat per edge from its list step.
// the row memory read is registered, which sets this order.
// a new item is accepted while a result still waits in the output register;
// a stalled output holds the block in its update or listing step.
// reset clears the row valid bits at once: every list starts empty.
module graph_adjacency_store
  import gas_pkg::*;
#(
  parameter int unsigned NUM_VERTICES = NUM_VERTICES_DEF,
  parameter int unsigned MAX_DEGREE   = MAX_DEGREE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // from_vertex, to_vertex, label_in
  input  logic [2:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // status, label_out, neighbor, neighbor_count, zero
  output logic        m_axis_tlast    // last
);

  localparam int unsigned ROWS   = (NUM_VERTICES < 256) ? NUM_VERTICES : 256;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned CNT_W  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned SLOT_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST
  } state_e;

  state_e state_q;

  logic [VERTEX_W-1:0] in_from, in_to;
  logic [LABEL_W-1:0]  in_label;
  kind_e               in_kind;
  logic                in_acc, in_bad;

  kind_e               kind_q;
  logic                bad_q;
  logic [VERTEX_W-1:0] to_q;
  logic [LABEL_W-1:0]  label_q;
  logic [ROW_W-1:0]    row_q;
  logic [SLOT_W-1:0]   idx_q;

  logic                m_valid_q;
  logic [STATUS_W-1:0] m_status_q;
  logic [LABEL_W-1:0]  m_label_q;
  logic [VERTEX_W-1:0] m_nb_q;
  logic [COUNT_W-1:0]  m_cnt_q;
  logic                m_last_q;

  logic [MAX_DEGREE-1:0][VERTEX_W-1:0] rd_tgt, wr_tgt;
  logic [MAX_DEGREE-1:0][LABEL_W-1:0]  rd_tag, wr_tag;
  logic [CNT_W-1:0]                    rd_deg, wr_deg;
  logic                                wr_en;

  logic [MAX_DEGREE-1:0] newest, at_or_above;
  logic                  found, seen, full, load_ok;
  logic [LABEL_W-1:0]    found_tag;
  logic                  list_beats, ret_label, beat_load;

  assign in_from  = s_axis_tdata[7:0];
  assign in_to    = s_axis_tdata[15:8];
  assign in_label = s_axis_tdata[47:16];
  assign in_kind  = kind_e'(s_axis_tuser);
  assign in_bad   = (32'(in_from) >= NUM_VERTICES) || (s_axis_tuser > KIND_LIST);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_ok       = !m_valid_q || m_axis_tready;

  gas_row_store #(
    .ROWS       (ROWS),
    .MAX_DEGREE (MAX_DEGREE),
    .ROW_W      (ROW_W),
    .CNT_W      (CNT_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (ROW_W'(in_from)),
    .wr_en_i   (wr_en),
    .wr_addr_i (row_q),
    .wr_tgt_i  (wr_tgt),
    .wr_tag_i  (wr_tag),
    .wr_deg_i  (wr_deg),
    .rd_tgt_o  (rd_tgt),
    .rd_tag_o  (rd_tag),
    .rd_deg_o  (rd_deg)
  );

  // newest matching edge as a one-hot, and the slots at or above it
  always_comb begin
    seen      = 1'b0;
    newest    = '0;
    found_tag = '0;
    for (int i = MAX_DEGREE - 1; i >= 0; i--) begin
      if (!seen && (CNT_W'(i) < rd_deg) && (rd_tgt[i] == to_q)) begin
        newest[i] = 1'b1;
        seen      = 1'b1;
      end
    end
    found = seen;
    for (int i = 0; i < MAX_DEGREE; i++) begin
      if (newest[i]) begin
        found_tag = rd_tag[i];
      end
    end
    at_or_above[0] = newest[0];
    for (int i = 1; i < MAX_DEGREE; i++) begin
      at_or_above[i] = at_or_above[i-1] | newest[i];
    end
  end

  assign full = (rd_deg == CNT_W'(MAX_DEGREE));

  // a non-empty listing sends its beats from the list step
  assign list_beats = !bad_q && (kind_q == KIND_LIST) && (rd_deg != '0);
  assign ret_label  = !bad_q && found && ((kind_q == KIND_REMOVE) || (kind_q == KIND_READ));
  assign beat_load  = load_ok && (((state_q == ST_EXEC) && !list_beats) ||
                                  (state_q == ST_LIST));

  // row update
  always_comb begin
    wr_tgt = rd_tgt;
    wr_tag = rd_tag;
    wr_deg = rd_deg;
    wr_en  = 1'b0;
    case (kind_q)
      KIND_ADD: begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
          if (CNT_W'(i) == rd_deg) begin
            wr_tgt[i] = to_q;
            wr_tag[i] = label_q;
          end
        end
        wr_deg = rd_deg + CNT_W'(1);
        wr_en  = !full;
      end
      KIND_REMOVE: begin
        // newer edges close up the gap
        for (int i = 0; i < MAX_DEGREE - 1; i++) begin
          if (at_or_above[i]) begin
            wr_tgt[i] = rd_tgt[i+1];
            wr_tag[i] = rd_tag[i+1];
          end
        end
        wr_deg = rd_deg - CNT_W'(1);
        wr_en  = found;
      end
      KIND_SET: begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
          if (newest[i]) begin
            wr_tag[i] = label_q;
          end
        end
        wr_en = found;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    wr_en = wr_en && !bad_q && (state_q == ST_EXEC) && load_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      kind_q    <= KIND_ADD;
      bad_q     <= 1'b0;
    end else begin
      if (beat_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            kind_q  <= in_kind;
            bad_q   <= in_bad;
            to_q    <= in_to;
            label_q <= in_label;
            row_q   <= ROW_W'(in_from);
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (load_ok) begin
            m_label_q <= ret_label ? found_tag : '0;
            m_nb_q    <= '0;
            m_cnt_q   <= '0;
            m_last_q  <= 1'b1;
            if (list_beats) begin
              // listing goes out beat by beat from the held row
              idx_q   <= SLOT_W'(rd_deg - CNT_W'(1));
              state_q <= ST_LIST;
            end else begin
              state_q <= ST_IDLE;
            end
            if (bad_q) begin
              m_status_q <= STATUS_NOTFOUND;
            end else begin
              case (kind_q)
                KIND_ADD: begin
                  m_status_q <= full ? STATUS_FULL : STATUS_OK;
                end
                KIND_LIST: begin
                  m_status_q <= STATUS_OK;
                end
                default: begin
                  m_status_q <= found ? STATUS_OK : STATUS_NOTFOUND;
                end
              endcase
            end
          end
        end
        ST_LIST: begin
          if (load_ok) begin
            m_status_q <= STATUS_OK;
            m_label_q  <= '0;
            m_nb_q     <= rd_tgt[idx_q];
            m_cnt_q    <= COUNT_W'(rd_deg);
            m_last_q   <= (idx_q == '0);
            idx_q      <= idx_q - SLOT_W'(1);
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {1'b0, m_cnt_q, m_nb_q, m_label_q, m_status_q};

endmodule

/* tb/graph_adjacency_checker.sv */
`timescale 1ns / 100ps

module graph_adjacency_checker
  import gas_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // from_vertex, to_vertex, label_in
  input  logic [2:0]  s_axis_tuser,   // kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // status, label_out, neighbor, neighbor_count, zero
  input  logic        m_axis_tlast,   // last
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    status_e            status;
    logic [LABEL_W-1:0] label;
    logic [7:0]         neighbor;
    logic [COUNT_W-1:0] count;
    logic               last;
  } edge_result_t;

  // shadow copy of the edge rows, oldest edge at slot 0
  logic [7:0]         row_target [NUM_VERTICES_DEF][MAX_DEGREE_DEF];
  logic [LABEL_W-1:0] row_label  [NUM_VERTICES_DEF][MAX_DEGREE_DEF];
  int                 row_degree [NUM_VERTICES_DEF];

  edge_result_t due_results[$];
  int           mismatches;

  function automatic int newest_slot(logic [7:0] vtx, logic [7:0] target);
    for (int i = row_degree[vtx] - 1; i >= 0; i--) begin
      if (row_target[vtx][i] == target) return i;
    end
    return -1;
  endfunction

  task automatic apply_edge_op(input logic [2:0] kind, input logic [7:0] from_v,
                               input logic [7:0] to_v, input logic [LABEL_W-1:0] label_in);
    edge_result_t res;
    int           deg;
    int           slot;
    bit           single;
    deg    = row_degree[from_v];
    slot   = newest_slot(from_v, to_v);
    single = 1'b1;
    res.status   = STATUS_OK;
    res.label    = '0;
    res.neighbor = '0;
    res.count    = '0;
    res.last     = 1'b1;
    case (kind)
      KIND_ADD: begin
        if (deg >= MAX_DEGREE_DEF) begin
          res.status = STATUS_FULL;
        end else begin
          row_target[from_v][deg] = to_v;
          row_label[from_v][deg]  = label_in;
          row_degree[from_v]      = deg + 1;
        end
      end
      KIND_REMOVE: begin
        if (slot < 0) begin
          res.status = STATUS_NOTFOUND;
        end else begin
          res.label = row_label[from_v][slot];
          // newer edges move down to close the gap
          for (int i = slot; i + 1 < deg; i++) begin
            row_target[from_v][i] = row_target[from_v][i+1];
            row_label[from_v][i]  = row_label[from_v][i+1];
          end
          row_degree[from_v] = deg - 1;
        end
      end
      KIND_READ: begin
        if (slot < 0) res.status = STATUS_NOTFOUND;
        else res.label = row_label[from_v][slot];
      end
      KIND_SET: begin
        if (slot < 0) res.status = STATUS_NOTFOUND;
        else row_label[from_v][slot] = label_in;
      end
      KIND_TEST: begin
        if (slot < 0) res.status = STATUS_NOTFOUND;
      end
      KIND_LIST: begin
        if (deg > 0) begin
          single = 1'b0;
          for (int i = 0; i < deg; i++) begin
            res.neighbor = row_target[from_v][deg-1-i];
            res.count    = COUNT_W'(deg);
            res.last     = (i + 1 == deg);
            due_results.push_back(res);
          end
        end
      end
      default: res.status = STATUS_NOTFOUND;
    endcase
    if (single) due_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [LABEL_W-1:0] want,
                             input logic [LABEL_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic check_beat();
    edge_result_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result beat with nothing expected, tdata %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
    end else begin
      want = due_results.pop_front();
      check_field("status", LABEL_W'(want.status), LABEL_W'(m_axis_tdata[1:0]));
      check_field("label_out", want.label, m_axis_tdata[33:2]);
      check_field("neighbor", LABEL_W'(want.neighbor), LABEL_W'(m_axis_tdata[41:34]));
      check_field("neighbor_count", LABEL_W'(want.count), LABEL_W'(m_axis_tdata[46:42]));
      check_field("last", LABEL_W'(want.last), LABEL_W'(m_axis_tlast));
      check_field("pad", '0, LABEL_W'(m_axis_tdata[47]));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (row_degree[v]) row_degree[v] = 0;
      due_results.delete();
      mismatches = 0;
    end else begin
      // results leave before the beat accepted at this edge can produce any
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (s_axis_tvalid && s_axis_tready)
        apply_edge_op(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                      s_axis_tdata[47:16]);
    end
    pending_o    <= due_results.size();
    fail_count_o <= mismatches;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import gas_pkg::*;

  localparam logic [2:0] KIND_BAD_LO = 3'd6;
  localparam logic [2:0] KIND_BAD_HI = 3'd7;
  localparam int HOLD_CYCLES = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;

  int   gap_pct = 0;
  int   stall_pct = 0;
  logic long_hold_on = 1'b0;
  event hold_request;

  always #6 clk_i = ~clk_i;

  graph_adjacency_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  graph_adjacency_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    if (long_hold_on) m_axis_tready <= 1'b0;
    else if (stall_pct == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  always begin
    @(hold_request);
    long_hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold_on <= 1'b0;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // called just after a rising edge; leaves tvalid high after the beat
  task automatic send_item(input logic [2:0] kind, input logic [7:0] from_v,
                           input logic [7:0] to_v, input logic [31:0] label_in);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {label_in, to_v, from_v};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(input int hot_vertices);
    logic [2:0]  kind;
    logic [7:0]  from_v;
    logic [7:0]  to_v;
    logic [31:0] label_in;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 36) kind = KIND_ADD;
    else if (pick < 50) kind = KIND_REMOVE;
    else if (pick < 62) kind = KIND_READ;
    else if (pick < 72) kind = KIND_SET;
    else if (pick < 82) kind = KIND_TEST;
    else if (pick < 95) kind = KIND_LIST;
    else kind = ($urandom_range(1) != 0) ? KIND_BAD_HI : KIND_BAD_LO;
    from_v = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                      : 8'($urandom_range(hot_vertices - 1));
    // a narrow target pool keeps matches and duplicates frequent
    to_v = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
    case ($urandom_range(9))
      0:       label_in = '0;
      1:       label_in = '1;
      default: label_in = $urandom;
    endcase
    send_item(kind, from_v, to_v, label_in);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ordering, duplicates and misses on vertex 0
    send_item(KIND_LIST,   8'd0, 8'd0,   32'h0);
    send_item(KIND_ADD,    8'd0, 8'd255, 32'hFFFF_FFFF);
    send_item(KIND_ADD,    8'd0, 8'd0,   32'h0);
    send_item(KIND_ADD,    8'd0, 8'd255, 32'h1);
    send_item(KIND_LIST,   8'd0, 8'd77,  32'h0);
    send_item(KIND_READ,   8'd0, 8'd255, 32'h0);
    send_item(KIND_SET,    8'd0, 8'd255, 32'hA5A5_5A5A);
    send_item(KIND_READ,   8'd0, 8'd255, 32'h0);
    send_item(KIND_TEST,   8'd0, 8'd0,   32'h0);
    send_item(KIND_TEST,   8'd0, 8'd7,   32'h0);
    send_item(KIND_REMOVE, 8'd0, 8'd7,   32'h0);
    send_item(KIND_READ,   8'd0, 8'd7,   32'h0);
    send_item(KIND_SET,    8'd0, 8'd7,   32'h1234_5678);
    send_item(KIND_REMOVE, 8'd0, 8'd0,   32'h0);
    send_item(KIND_REMOVE, 8'd0, 8'd255, 32'h0);
    send_item(KIND_LIST,   8'd0, 8'd0,   32'h0);
    send_item(KIND_BAD_LO, 8'd0, 8'd255, 32'hFFFF_FFFF);
    send_item(KIND_BAD_HI, 8'd0, 8'd255, 32'hFFFF_FFFF);

    // fill vertex 255 to the limit, then one add too many
    for (int i = 0; i < MAX_DEGREE_DEF; i++)
      send_item(KIND_ADD, 8'd255, 8'(i * 17), ~(32'h1 << i));
    send_item(KIND_ADD,  8'd255, 8'd1, 32'hDEAD_BEEF);
    send_item(KIND_LIST, 8'd255, 8'd0, 32'h0);
    wait_drained();

    gap_pct = 0;  stall_pct <= 0;
    repeat (45) send_random(3);
    gap_pct = 82; stall_pct <= 0;
    repeat (45) send_random(4);
    gap_pct = 0;  stall_pct <= 82;
    repeat (45) send_random(4);
    gap_pct = 27; stall_pct <= 27;
    repeat (45) send_random(6);

    wait_drained();
    gap_pct = 0; stall_pct <= 0;
    -> hold_request;
    repeat (40) send_random(4);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
